### hdl/esl_pkg.sv
// ----------------------------------------------------------------------------
// esl_pkg
// Shared types for the exchange sort list: input item, result item and the
// command that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package esl_pkg;

	localparam int ValueW = 32;

	typedef struct packed {
		logic signed [ValueW-1:0] value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [ValueW-1:0] value_res;
		logic                     last_res;
		logic                     dropped;
	} result_t;

	typedef struct packed {
		logic  append;
		logic  overflow;
		item_t item;
	} cmd_t;

endpackage

### hdl/exchange_sort_list.sv
// ----------------------------------------------------------------------------
// exchange_sort_list
// Collects a set of signed values and returns them sorted ascending.
// ----------------------------------------------------------------------------
// Items are taken while the queue is not full. On the item marked last, a set
// of n values is sorted in the back part, one compare per cycle through the
// single write port and single read port of the store, and the n results then
// leave one by one through the output register. A two-entry queue lets new
// items be taken while the back part is still busy with the previous set.
module exchange_sort_list import esl_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	cmd_t q_in;
	cmd_t q_out;

	esl_front #(.CAPACITY(CAPACITY)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_in)
	);

	esl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.pop    (q_pop),
		.dout   (q_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	esl_back #(.CAPACITY(CAPACITY)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (q_out),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### hdl/esl_front.sv
// ----------------------------------------------------------------------------
// esl_front
// Accepts input items and classifies each one as stored or dropped, keeping
// the fill count and the overflow flag of the current set.
// ----------------------------------------------------------------------------
module esl_front import esl_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          has_room;

	assign has_room   = count_q < CW'(CAPACITY);
	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		q_cmd.append   = has_room;
		q_cmd.overflow = ovf_q || !has_room;
		q_cmd.item     = item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (q_push) begin
			if (item.last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (has_room) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

### hdl/esl_queue.sv
// ----------------------------------------------------------------------------
// esl_queue
// Two-entry command queue between the front part and the back part.
// ----------------------------------------------------------------------------
module esl_queue import esl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic full,
	output logic empty
);

	cmd_t       entry_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Queue written while full.");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Queue read while empty.");

endmodule

### hdl/esl_back.sv
// ----------------------------------------------------------------------------
// esl_back
// Stores appended values in a local memory, sorts a closed set ascending by
// exchange sort and sends the sorted values through an output register.
// ----------------------------------------------------------------------------
module esl_back import esl_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  cmd_t    q_cmd,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_RDI  = 3'd1;
	localparam logic [2:0] S_LDI  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_WRI  = 3'd4;
	localparam logic [2:0] S_ORD  = 3'd5;
	localparam logic [2:0] S_OLD  = 3'd6;

	logic signed [ValueW-1:0] mem [CAPACITY];
	logic signed [ValueW-1:0] rdata_q;
	logic signed [ValueW-1:0] cur_q;
	logic signed [ValueW-1:0] wr_data;
	logic [2:0]               state_q;
	logic [CW-1:0]            wcnt_q;
	logic [CW-1:0]            n_q;
	logic [CW-1:0]            i_q;
	logic [CW-1:0]            j_q;
	logic [CW-1:0]            k_q;
	logic                     drop_q;
	logic                     rd_en;
	logic [CW-1:0]            rd_addr;
	logic                     wr_en;
	logic [CW-1:0]            wr_addr;
	logic                     out_load;
	logic                     out_vld_q;
	result_t                  out_q;
	logic                     swap;

	assign q_pop        = (state_q == S_LOAD) && !q_empty;
	assign out_load     = !out_vld_q || !result_stall;
	assign swap         = cur_q > rdata_q;
	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q;
		wr_en   = 1'b0;
		wr_addr = j_q;
		wr_data = cur_q;
		unique case (state_q)
			S_LOAD: begin
				wr_en   = q_pop && q_cmd.append;
				wr_addr = wcnt_q;
				wr_data = q_cmd.item.value;
			end
			S_RDI: begin
				rd_en = 1'b1;
			end
			S_LDI: begin
				rd_en   = 1'b1;
				rd_addr = i_q + CW'(1);
			end
			S_CMP: begin
				wr_en   = swap;
				rd_en   = (j_q + CW'(1)) < n_q;
				rd_addr = j_q + CW'(1);
			end
			S_WRI: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				rd_en   = (i_q + CW'(2)) < n_q;
				rd_addr = i_q + CW'(1);
			end
			S_ORD: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LDI) begin
			cur_q <= rdata_q;
		end else if (state_q == S_CMP && swap) begin
			cur_q <= rdata_q;
		end
		if (state_q == S_OLD && out_load) begin
			out_q.value_res <= rdata_q;
			out_q.last_res  <= (k_q + CW'(1)) == n_q;
			out_q.dropped   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			wcnt_q    <= '0;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			drop_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == S_OLD && out_load) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (q_pop) begin
						if (q_cmd.item.last) begin
							n_q    <= wcnt_q + CW'(q_cmd.append);
							drop_q <= q_cmd.overflow;
							wcnt_q <= '0;
							i_q    <= '0;
							k_q    <= '0;
							if ((wcnt_q + CW'(q_cmd.append)) == CW'(1)) begin
								state_q <= S_ORD;
							end else begin
								state_q <= S_RDI;
							end
						end else if (q_cmd.append) begin
							wcnt_q <= wcnt_q + CW'(1);
						end
					end
				end
				S_RDI: begin
					state_q <= S_LDI;
				end
				S_LDI: begin
					j_q     <= i_q + CW'(1);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ((j_q + CW'(1)) < n_q) begin
						j_q <= j_q + CW'(1);
					end else begin
						state_q <= S_WRI;
					end
				end
				S_WRI: begin
					if ((i_q + CW'(2)) < n_q) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_LDI;
					end else begin
						state_q <= S_ORD;
					end
				end
				S_ORD: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					if (out_load) begin
						if ((k_q + CW'(1)) == n_q) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= CW'(CAPACITY))
		else $error("Fill count exceeds the store size.");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (j_q > i_q) && (j_q < n_q))
		else $error("Compare pair out of order or out of range.");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OLD) |-> (k_q < n_q))
		else $error("Emit index beyond the set size.");

endmodule

### tb/exchange_sort_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exchange_sort_list_test
// Drives sets of signed values into the sorter, predicts the ascending output
// of each set, including the flag for items lost to a full store, and checks
// every result transfer against the prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module exchange_sort_list_test;
	import esl_pkg::*;

	localparam int Capacity = 16;
	localparam int HalfPeriod = 4;
	localparam int ResetCycles = 4;
	localparam int RandomItems = 500;
	localparam int TailCycles = 300;
	localparam int TimeoutNs = 3_200_000;
	localparam logic signed [ValueW-1:0] MinValue = 32'sh8000_0000;
	localparam logic signed [ValueW-1:0] MaxValue = 32'sh7fff_ffff;

	typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGE} value_mix_t;

	class sorted_set_tracker;
		logic signed [ValueW-1:0] held[Capacity];
		int held_count;
		bit overflow_seen;
		result_t sorted_due[$];
		int mismatches;
		int sets_closed;
		int overflow_sets;
		int results_checked;

		function new();
			held_count = 0;
			overflow_seen = 1'b0;
			mismatches = 0;
			sets_closed = 0;
			overflow_sets = 0;
			results_checked = 0;
		endfunction

		function int pending();
			return sorted_due.size();
		endfunction

		function void note_item(item_t it);
			logic signed [ValueW-1:0] swap;
			result_t r;
			if (held_count < Capacity) begin
				held[held_count] = it.value;
				held_count++;
			end else begin
				overflow_seen = 1'b1;
			end
			if (it.last) begin
				for (int i = 0; i + 1 < held_count; i++) begin
					for (int j = i + 1; j < held_count; j++) begin
						if (held[i] > held[j]) begin
							swap = held[i];
							held[i] = held[j];
							held[j] = swap;
						end
					end
				end
				for (int k = 0; k < held_count; k++) begin
					r.value_res = held[k];
					r.last_res = (k == held_count - 1);
					r.dropped = overflow_seen;
					sorted_due.push_back(r);
				end
				sets_closed++;
				if (overflow_seen)
					overflow_sets++;
				held_count = 0;
				overflow_seen = 1'b0;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_checked++;
			if (sorted_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, value_res %0d last_res %0b dropped %0b",
					$time, got.value_res, got.last_res, got.dropped);
				return;
			end
			want = sorted_due.pop_front();
			if (got.value_res !== want.value_res) begin
				mismatches++;
				$display("%0t: value_res expected %0d actual %0d",
					$time, want.value_res, got.value_res);
			end
			if (got.last_res !== want.last_res) begin
				mismatches++;
				$display("%0t: last_res expected %0b actual %0b",
					$time, want.last_res, got.last_res);
			end
			if (got.dropped !== want.dropped) begin
				mismatches++;
				$display("%0t: dropped expected %0b actual %0b",
					$time, want.dropped, got.dropped);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	bit quiet = 1'b0;
	int sent_items = 0;
	sorted_set_tracker tracker;

	exchange_sort_list #(
		.CAPACITY(Capacity)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #(HalfPeriod) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(result);
		result_stall <= !quiet && ($urandom_range(0, 99) < 9);
	end

	function automatic item_t make_item(logic signed [ValueW-1:0] value, logic last);
		item_t it;
		it.value = value;
		it.last = last;
		return it;
	endfunction

	function automatic logic signed [ValueW-1:0] pick_value(value_mix_t mix);
		int narrow;
		case (mix)
			MIX_NARROW: begin
				narrow = int'($urandom_range(0, 7)) - 4;
				return narrow;
			end
			MIX_EDGE: begin
				case ($urandom_range(0, 5))
					0: return MinValue;
					1: return MaxValue;
					2: return 0;
					3: return -1;
					4: return MinValue + 1;
					default: return MaxValue - 1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input item_t it);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		tracker.note_item(it);
		sent_items++;
	endtask

	task automatic send_set(input int n, input value_mix_t mix);
		for (int k = 0; k < n; k++)
			send_item(make_item(pick_value(mix), k == n - 1));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int stored_items;
		int roll;
		int n;
		bit drained_mid;
		value_mix_t mix;
		tracker = new();
		stored_items = 0;
		drained_mid = 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_item(MinValue, 1'b1));
		send_item(make_item(MaxValue, 1'b1));
		send_item(make_item(MaxValue, 1'b0));
		send_item(make_item(0, 1'b0));
		send_item(make_item(-1, 1'b0));
		send_item(make_item(MinValue, 1'b0));
		send_item(make_item(7, 1'b0));
		send_item(make_item(7, 1'b1));
		// A descending full store, closed by an item that finds no room.
		for (int k = 0; k < Capacity; k++)
			send_item(make_item((Capacity - 1 - k) * 1000 - 8000, 1'b0));
		send_item(make_item(0, 1'b1));
		wait_drained();

		while (stored_items < RandomItems) begin
			roll = $urandom_range(0, 99);
			if (roll < 60)
				n = $urandom_range(1, 6);
			else if (roll < 80)
				n = $urandom_range(7, Capacity - 1);
			else if (roll < 90)
				n = Capacity;
			else
				n = $urandom_range(Capacity + 1, Capacity + 6);
			mix = value_mix_t'($urandom_range(0, 2));
			quiet = (stored_items >= 150 && stored_items < 260);
			if (!drained_mid && stored_items >= 320) begin
				wait_drained();
				drained_mid = 1'b1;
			end
			send_set(n, mix);
			stored_items += (n < Capacity) ? n : Capacity;
		end

		quiet = 1'b0;
		wait_drained();
		repeat (TailCycles) @(posedge clk);
		$display("Sent %0d items in %0d sets, %0d of them over capacity.",
			sent_items, tracker.sets_closed, tracker.overflow_sets);
		$display("Checked %0d sorted results.", tracker.results_checked);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("exchange_sort_list: match");
		else
			$display("exchange_sort_list: mismatch");
		$finish;
	end

	initial begin
		#(TimeoutNs);
		$display("Run timed out.");
		$display("exchange_sort_list: mismatch");
		$finish;
	end

endmodule

### files.f
hdl/esl_pkg.sv
hdl/esl_front.sv
hdl/esl_queue.sv
hdl/esl_back.sv
hdl/exchange_sort_list.sv
tb/exchange_sort_list_test.sv
